// ===== hdl/pol_pkg.sv =====
package pol_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W = 5;
  localparam int ENTRIES_W = 5;

  // request codes
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;
  localparam logic [2:0] REQ_DUMP   = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ===== hdl/pol_cell.sv =====
module pol_cell #(
  parameter int IDX = 0,
  parameter int CW = 5
) (
  input  logic                                 clk,
  input  pol_pkg::cell_ctl_t                   ctl,
  input  logic [CW-1:0]                        count,
  input  logic signed [pol_pkg::VALUE_W-1:0]   value,
  input  logic signed [pol_pkg::VALUE_W-1:0]   left,
  input  logic signed [pol_pkg::VALUE_W-1:0]   right,
  input  logic signed [pol_pkg::VALUE_W-1:0]   head,
  output logic signed [pol_pkg::VALUE_W-1:0]   data,
  output logic                                 match
);

  localparam int CMPW = (CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W;

  logic [CMPW-1:0] idx_c;
  logic [CMPW-1:0] idx_inc;
  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  logic signed [pol_pkg::VALUE_W-1:0] data_next;

  assign idx_c   = CMPW'(IDX);
  assign idx_inc = CMPW'(IDX + 1);
  assign pos_c   = CMPW'(ctl.pos);
  assign cnt_c   = CMPW'(count);

  always_comb begin
    data_next = data;
    unique case (ctl.cmd)
      pol_pkg::CELL_HOLD: data_next = data;
      pol_pkg::CELL_APP: begin
        if (idx_c == cnt_c) data_next = value;
      end
      pol_pkg::CELL_INS: begin
        if (idx_c == pos_c) data_next = value;
        else if (idx_c > pos_c) data_next = left;
      end
      // cells at or past the removed slot pull from the right
      pol_pkg::CELL_DEL: begin
        if (idx_inc >= pos_c) data_next = right;
      end
      // rotate toward the head, the last used cell wraps around
      pol_pkg::CELL_ROT: begin
        if (idx_inc == cnt_c) data_next = head;
        else data_next = right;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data  <= data_next;
    match <= (data == value) && (idx_c < cnt_c);
  end

endmodule

// ===== hdl/positional_ordered_list_unit.sv =====
// latency: clear, append, insert, delete and unknown codes give one word the cycle after start
// search gives its word two cycles after start (compare in the cells, then reduce the hits)
// dump streams one word per cycle from the head cell, count words, busy for count cycles
// throughput: one-word requests back to back, search every 2 cycles, dump every count+1
// reset: synchronous, empties the list; cell storage is not cleared, receiver cannot stall
module positional_ordered_list_unit #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           req_type,
  input  logic [pol_pkg::POS_W-1:0]            position,
  input  logic signed [pol_pkg::VALUE_W-1:0]   value,
  output logic                                 strobe,
  output logic [1:0]                           status,
  output logic                                 found,
  output logic                                 has_value,
  output logic signed [pol_pkg::VALUE_W-1:0]   element,
  output logic [pol_pkg::ENTRIES_W-1:0]        entries,
  output logic                                 last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_DUMP
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] dump_idx;
  logic [1:0] status_next;
  logic accept;
  logic dump_last;
  logic full;
  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  pol_pkg::cell_ctl_t ctl;

  logic signed [pol_pkg::VALUE_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] match;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CW'(DEPTH));
  assign pos_c     = CMPW'(position);
  assign cnt_c     = CMPW'(count);
  assign dump_last = ((dump_idx + CW'(1)) == count);

  always_comb begin
    ctl.cmd     = pol_pkg::CELL_HOLD;
    ctl.pos     = position;
    status_next = pol_pkg::ST_OK;
    count_next  = count;
    if (state == S_DUMP) begin
      ctl.cmd = pol_pkg::CELL_ROT;
    end else if (accept) begin
      unique case (req_type)
        pol_pkg::REQ_CLEAR: count_next = '0;
        pol_pkg::REQ_APPEND: begin
          if (full) begin
            status_next = pol_pkg::ST_FULL;
          end else begin
            ctl.cmd    = pol_pkg::CELL_APP;
            count_next = count + CW'(1);
          end
        end
        pol_pkg::REQ_INSERT: begin
          if (pos_c > cnt_c) begin
            status_next = pol_pkg::ST_BAD_POS;
          end else if (full) begin
            status_next = pol_pkg::ST_FULL;
          end else begin
            ctl.cmd    = pol_pkg::CELL_INS;
            count_next = count + CW'(1);
          end
        end
        pol_pkg::REQ_DELETE: begin
          if (position == '0 || pos_c > cnt_c) begin
            status_next = pol_pkg::ST_BAD_POS;
          end else begin
            ctl.cmd    = pol_pkg::CELL_DEL;
            count_next = count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pol_cell #(
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .count(count),
      .value(value),
      .left (cell_data[(g > 0) ? g - 1 : 0]),
      .right(cell_data[(g < DEPTH - 1) ? g + 1 : g]),
      .head (cell_data[0]),
      .data (cell_data[g]),
      .match(match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      strobe   <= 1'b0;
      dump_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            status    <= status_next;
            found     <= 1'b0;
            has_value <= 1'b0;
            element   <= '0;
            last      <= 1'b1;
            entries   <= pol_pkg::ENTRIES_W'(count_next);
            count     <= count_next;
            dump_idx  <= '0;
            if (req_type == pol_pkg::REQ_SEARCH) begin
              state  <= S_SRCH;
              strobe <= 1'b0;
            end else if (req_type == pol_pkg::REQ_DUMP && count != '0) begin
              state  <= S_DUMP;
              strobe <= 1'b0;
            end else begin
              strobe <= 1'b1;
            end
          end else begin
            strobe <= 1'b0;
          end
        end
        S_SRCH: begin
          strobe <= 1'b1;
          found  <= |match;
          state  <= S_IDLE;
        end
        S_DUMP: begin
          strobe    <= 1'b1;
          status    <= pol_pkg::ST_OK;
          found     <= 1'b0;
          has_value <= 1'b1;
          element   <= cell_data[0];
          entries   <= pol_pkg::ENTRIES_W'(count);
          last      <= dump_last;
          dump_idx  <= dump_idx + CW'(1);
          if (dump_last) state <= S_IDLE;
        end
        default: begin
          state  <= S_IDLE;
          strobe <= 1'b0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count changed without a request");

  a_final_word_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final word while still busy");

  a_mid_dump_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy && has_value)
    else $error("non-final word outside a dump");

  a_dump_word_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && has_value |-> status == pol_pkg::ST_OK && !found)
    else $error("dump word with status or found set");

endmodule
